// ----- rtl/ookpwm_pkg.sv -----
// ----------------------------------------------------------------------------
// ookpwm_pkg
// Shared types and codes for the on-off-keyed pulse-width frame encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ookpwm_pkg;

  localparam int unsigned TIME_W      = 16;
  localparam int unsigned FRAME_W     = 64;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned COUNT_W     = 8;
  localparam int unsigned OP_W        = 2;
  localparam int unsigned BIT_IDX_W   = 7;
  localparam int unsigned CFG_IDX_W   = 3;

  localparam logic [BIT_IDX_W-1:0] FRAME_BIT_COUNT = 7'd64;
  localparam logic [COUNT_W-1:0]   COUNT_MAX       = 8'd255;

  typedef enum logic [OP_W-1:0] {
    OP_START = 2'd0,
    OP_NEXT  = 2'd1,
    OP_STOP  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ONE_HIGH      = 3'd0,
    REG_ONE_LOW       = 3'd1,
    REG_ZERO_HIGH     = 3'd2,
    REG_ZERO_LOW      = 3'd3,
    REG_PREAMBLE_HIGH = 3'd4,
    REG_PREAMBLE_LOW  = 3'd5,
    REG_FRAME_GAP     = 3'd6,
    REG_UNUSED        = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PH_PRE_HIGH = 3'b001,
    PH_PRE_LOW  = 3'b010,
    PH_DATA     = 3'b100
  } phase_t;

  localparam logic [TIME_W-1:0] RST_ONE_HIGH      = 16'd560;
  localparam logic [TIME_W-1:0] RST_ONE_LOW       = 16'd280;
  localparam logic [TIME_W-1:0] RST_ZERO_HIGH     = 16'd280;
  localparam logic [TIME_W-1:0] RST_ZERO_LOW      = 16'd560;
  localparam logic [TIME_W-1:0] RST_PREAMBLE_HIGH = 16'd8000;
  localparam logic [TIME_W-1:0] RST_PREAMBLE_LOW  = 16'd4000;
  localparam logic [TIME_W-1:0] RST_FRAME_GAP     = 16'd12000;

endpackage

`default_nettype wire

// ----- rtl/ookpwm_req_if.sv -----
// ----------------------------------------------------------------------------
// ookpwm_req_if
// Request channel: valid/ready handshake with op, frame words and repeat count.
// ----------------------------------------------------------------------------
`default_nettype none

interface ookpwm_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] frame_high_word;
  logic [31:0] frame_low_word;
  logic [7:0]  repeat_count;

  modport source (
    output valid, op, frame_high_word, frame_low_word, repeat_count,
    input  ready
  );
  modport sink (
    input  valid, op, frame_high_word, frame_low_word, repeat_count,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/ookpwm_seg_if.sv -----
// ----------------------------------------------------------------------------
// ookpwm_seg_if
// Segment channel: valid/ready handshake with level, length and finished flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface ookpwm_seg_if;
  logic        valid;
  logic        ready;
  logic        line_level;
  logic [15:0] segment_length;
  logic        finished;

  modport source (
    output valid, line_level, segment_length, finished,
    input  ready
  );
  modport sink (
    input  valid, line_level, segment_length, finished,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/ook_pwm_frame_encoder.sv -----
// ----------------------------------------------------------------------------
// ook_pwm_frame_encoder
// Emits one level/duration segment per next-segment request for an on-off
// keyed pulse-width frame: preamble, 64 data bits MSB first, inter-frame gap.
// ----------------------------------------------------------------------------
// Output: a next-segment beat's segment is registered and shows in the cycle after acceptance.
// Throughput: one request beat per cycle while the output register is empty or being
// drained; the single output register takes a new segment in the same cycle that the previous one is drained.
// Reset: synchronous; timing registers return to defaults, encoder goes idle,
// output register empties.
`default_nettype none

module ook_pwm_frame_encoder (
  input  wire logic                          clk,
  input  wire logic                          rst,
  ookpwm_req_if.sink                         req,
  ookpwm_seg_if.source                       seg,
  input  wire logic                          cfg_we,
  input  wire logic [ookpwm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ookpwm_pkg::TIME_W-1:0]    cfg_data
);
  import ookpwm_pkg::*;

  logic [TIME_W-1:0] one_high_time, one_low_time, zero_high_time, zero_low_time;
  logic [TIME_W-1:0] preamble_high_time, preamble_low_time, frame_gap_time;

  logic [FRAME_W-1:0]   frame_bits;
  logic                 active;
  phase_t               phase;
  logic [BIT_IDX_W-1:0] bit_index;
  logic                 low_half;
  logic [COUNT_W-1:0]   frames_sent;
  logic [COUNT_W-1:0]   frames_wanted;

  logic                 seg_valid;
  logic                 seg_level;
  logic [TIME_W-1:0]    seg_length;
  logic                 seg_finished;

  logic                 active_next;
  phase_t               phase_next;
  logic [BIT_IDX_W-1:0] bit_index_next;
  logic                 low_half_next;
  logic [COUNT_W-1:0]   frames_sent_next;
  logic                 emit;
  logic                 emit_level;
  logic [TIME_W-1:0]    emit_length;
  logic                 emit_finished;

  logic                 accept;
  logic                 cur_bit;
  logic [COUNT_W-1:0]   sent_inc;
  op_t                  op;

  assign op        = op_t'(req.op);
  assign req.ready = !seg_valid || seg.ready;
  assign accept    = req.valid && req.ready;

  assign seg.valid          = seg_valid;
  assign seg.line_level     = seg_level;
  assign seg.segment_length = seg_length;
  assign seg.finished       = seg_finished;

  assign cur_bit  = frame_bits[~bit_index[5:0]];
  assign sent_inc = (frames_sent < COUNT_MAX) ? frames_sent + 1'b1 : frames_sent;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      one_high_time      <= RST_ONE_HIGH;
      one_low_time       <= RST_ONE_LOW;
      zero_high_time     <= RST_ZERO_HIGH;
      zero_low_time      <= RST_ZERO_LOW;
      preamble_high_time <= RST_PREAMBLE_HIGH;
      preamble_low_time  <= RST_PREAMBLE_LOW;
      frame_gap_time     <= RST_FRAME_GAP;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ONE_HIGH:      one_high_time      <= cfg_data;
        REG_ONE_LOW:       one_low_time       <= cfg_data;
        REG_ZERO_HIGH:     zero_high_time     <= cfg_data;
        REG_ZERO_LOW:      zero_low_time      <= cfg_data;
        REG_PREAMBLE_HIGH: preamble_high_time <= cfg_data;
        REG_PREAMBLE_LOW:  preamble_low_time  <= cfg_data;
        REG_FRAME_GAP:     frame_gap_time     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next segment and sequencer state for a next-segment request
  always_comb begin
    active_next      = active;
    phase_next       = phase;
    bit_index_next   = bit_index;
    low_half_next    = low_half;
    frames_sent_next = frames_sent;
    emit_level       = 1'b0;
    emit_length      = '0;
    emit_finished    = 1'b0;
    if (!active) begin
      emit_finished = 1'b1;
    end else begin
      priority case (phase)
        PH_PRE_HIGH: begin
          phase_next  = PH_PRE_LOW;
          emit_level  = 1'b1;
          emit_length = preamble_high_time;
        end
        PH_PRE_LOW: begin
          phase_next     = PH_DATA;
          bit_index_next = '0;
          low_half_next  = 1'b0;
          emit_length    = preamble_low_time;
        end
        default: begin
          if (bit_index < FRAME_BIT_COUNT) begin
            if (!low_half) begin
              low_half_next = 1'b1;
              emit_level    = 1'b1;
              emit_length   = cur_bit ? one_high_time : zero_high_time;
            end else begin
              low_half_next  = 1'b0;
              bit_index_next = bit_index + 1'b1;
              emit_length    = cur_bit ? one_low_time : zero_low_time;
            end
          end else begin
            frames_sent_next = sent_inc;
            if (sent_inc >= frames_wanted) begin
              active_next   = 1'b0;
              emit_finished = 1'b1;
            end else begin
              phase_next     = PH_PRE_HIGH;
              bit_index_next = '0;
              low_half_next  = 1'b0;
              emit_length    = frame_gap_time;
            end
          end
        end
      endcase
    end
  end

  assign emit = accept && (op == OP_NEXT);

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_bits    <= '0;
      active        <= 1'b0;
      phase         <= PH_PRE_HIGH;
      bit_index     <= '0;
      low_half      <= 1'b0;
      frames_sent   <= '0;
      frames_wanted <= '0;
    end else if (accept) begin
      unique case (op)
        OP_START: begin
          frame_bits    <= {req.frame_high_word, req.frame_low_word};
          frames_wanted <= req.repeat_count;
          frames_sent   <= '0;
          phase         <= PH_PRE_HIGH;
          bit_index     <= '0;
          low_half      <= 1'b0;
          active        <= 1'b1;
        end
        OP_STOP: active <= 1'b0;
        OP_NEXT: begin
          active      <= active_next;
          phase       <= phase_next;
          bit_index   <= bit_index_next;
          low_half    <= low_half_next;
          frames_sent <= frames_sent_next;
        end
        default: ;
      endcase
    end
  end

  // Output register: load on next-segment request beat, drop once drained
  always_ff @(posedge clk) begin
    if (rst) begin
      seg_valid <= 1'b0;
    end else if (emit) begin
      seg_valid <= 1'b1;
    end else if (seg.ready) begin
      seg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      seg_level    <= emit_level;
      seg_length   <= emit_length;
      seg_finished <= emit_finished;
    end
  end

endmodule

`default_nettype wire
